### design/qdsf_pkg.sv
// ============================================================================
// qdsf_pkg
// Shared types and constants of the quadrature decoder with speed filter.
// ============================================================================
package qdsf_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int PROD_W      = COUNT_WIDTH + 32;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SCALE = 2'd2;

    localparam logic [31:0] SPEED_SCALE_RST = 32'd0;
    localparam logic [16:0] FILTER_COEF_RST = 17'd6554;
    localparam logic [31:0] ANGLE_SCALE_RST = 32'd961263;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_UP,
        CMD_DOWN,
        CMD_TICK
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SPMUL,
        BK_SAT,
        BK_FMUL,
        BK_FILT,
        BK_AMUL,
        BK_ACC
    } t_back_state;

    typedef struct packed {
        logic [31:0] speed_scale;
        logic [16:0] filter_coef;
        logic [31:0] angle_scale;
    } t_cfg;

endpackage

### design/qdsf_in_if.sv
// ============================================================================
// qdsf_in_if
// Input channel: one pin sample or speed tick per item.
// ============================================================================
interface qdsf_in_if;
    logic valid;
    logic ready;
    logic action;
    logic pin_a;
    logic pin_b;

    modport source (output valid, output action, output pin_a, output pin_b, input ready);
    modport sink (input valid, input action, input pin_a, input pin_b, output ready);
endinterface

### design/qdsf_out_if.sv
// ============================================================================
// qdsf_out_if
// Result channel: count, speeds and angle after each item.
// ============================================================================
interface qdsf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_count;
    logic signed [31:0] raw_speed;
    logic signed [31:0] filtered_speed;
    logic signed [47:0] angle_degrees;

    modport source (
        output valid, output position_count, output raw_speed,
        output filtered_speed, output angle_degrees, input ready
    );
    modport sink (
        input valid, input position_count, input raw_speed,
        input filtered_speed, input angle_degrees, output ready
    );
endinterface

### design/qdsf_cfg_if.sv
// ============================================================================
// qdsf_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
interface qdsf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### design/quadrature_decoder_speed_filter.sv
// ============================================================================
// quadrature_decoder_speed_filter
// One quadrature encoder channel with speed estimate, low-pass filter and
// saturating angle accumulator, in Q16.16 fixed point.
// ============================================================================
// Every accepted item returns one result with the current count, raw speed,
// filtered speed and angle. A pin sample is decoded by the front, queued and
// executed by the back, so samples stream at one item per cycle while results
// are taken. A speed tick runs through the back's sequencer states SPMUL,
// SAT, FMUL, FILT, AMUL and ACC, with three multiply steps (speed scale,
// filter weight, angle scale), each followed by a register. A two-entry
// command queue lets the front keep taking pin samples while a tick is in
// progress. Configuration writes are taken in every cycle.
module quadrature_decoder_speed_filter (
    input  logic i_clk,
    input  logic i_rst_n,
    qdsf_in_if.sink     i_item,
    qdsf_out_if.source  o_result,
    qdsf_cfg_if.sink    i_cfg
);
    import qdsf_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_scale <= SPEED_SCALE_RST;
            r_cfg.filter_coef <= FILTER_COEF_RST;
            r_cfg.angle_scale <= ANGLE_SCALE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SPEED_SCALE: r_cfg.speed_scale <= i_cfg.data;
                REG_FILTER_COEF: r_cfg.filter_coef <= i_cfg.data[16:0];
                REG_ANGLE_SCALE: r_cfg.angle_scale <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    qdsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    qdsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    qdsf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cmd    (head_cmd),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

### design/qdsf_front.sv
// ============================================================================
// qdsf_front
// Accepts items, decodes the pin transition and issues one command per item.
// ============================================================================
module qdsf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qdsf_in_if.sink       i_item,
    input  logic          i_full,
    output logic          o_push,
    output qdsf_pkg::t_cmd o_cmd
);
    import qdsf_pkg::*;

    logic [1:0] r_prev_pins;
    logic [1:0] cur_pins;
    logic [1:0] step;
    logic       accept;

    function automatic logic [1:0] gray_pos(input logic [1:0] pins);
        logic [1:0] pos;
        unique case (pins)
            2'b00:   pos = 2'd0;
            2'b01:   pos = 2'd1;
            2'b11:   pos = 2'd2;
            default: pos = 2'd3;
        endcase
        return pos;
    endfunction

    assign i_item.ready = !i_full;
    assign accept       = i_item.valid && !i_full;
    assign o_push       = accept;
    assign cur_pins     = {i_item.pin_a, i_item.pin_b};
    assign step         = gray_pos(cur_pins) - gray_pos(r_prev_pins);

    always_comb begin
        if (i_item.action) begin
            o_cmd = CMD_TICK;
        end else begin
            unique case (step)
                2'd1:    o_cmd = CMD_UP;
                2'd3:    o_cmd = CMD_DOWN;
                default: o_cmd = CMD_HOLD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pins <= 2'b00;
        end else if (accept && !i_item.action) begin
            r_prev_pins <= cur_pins;
        end
    end

endmodule

### design/qdsf_queue.sv
// ============================================================================
// qdsf_queue
// Short command queue between the decoder front and the arithmetic back.
// ============================================================================
module qdsf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qdsf_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output qdsf_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import qdsf_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QFILL_W-1:0]  r_fill;

    assign o_full  = (r_fill == QFILL_W'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + QFILL_W'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - QFILL_W'(1);
            end
        end
    end

endmodule

### design/qdsf_back.sv
// ============================================================================
// qdsf_back
// Executes commands: position count, speed scaling, low-pass filter and
// angle accumulation, with a registered result stage.
// ============================================================================
module qdsf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qdsf_pkg::t_cfg i_cfg,
    input  qdsf_pkg::t_cmd i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    qdsf_out_if.source     o_result
);
    import qdsf_pkg::*;

    localparam int FPROD_W = 51;
    localparam logic [47:0] ANGLE_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] ANGLE_MIN = 48'h8000_0000_0000;
    localparam logic [16:0] COEF_ONE  = 17'd65536;

    t_back_state r_state, n_state;

    logic [COUNT_WIDTH-1:0]   r_count, n_count;
    logic [COUNT_WIDTH-1:0]   r_last, n_last;
    logic [COUNT_WIDTH-1:0]   r_mag, n_mag;
    logic                     r_neg, n_neg;
    logic [PROD_W-1:0]        r_sprod, n_sprod;
    logic [31:0]              r_raw, n_raw;
    logic signed [32:0]       r_dlt, n_dlt;
    logic signed [FPROD_W-1:0] r_fprod, n_fprod;
    logic [31:0]              r_filt, n_filt;
    logic                     r_aneg, n_aneg;
    logic [63:0]              r_aprod, n_aprod;
    logic [47:0]              r_angle, n_angle;

    logic                     r_out_valid, n_out_valid;
    logic [31:0]              r_out_pos, n_out_pos;
    logic [31:0]              r_out_raw, n_out_raw;
    logic [31:0]              r_out_filt, n_out_filt;
    logic [47:0]              r_out_angle, n_out_angle;

    logic                     slot_free;
    logic                     load;
    logic [COUNT_WIDTH-1:0]   du;
    logic [PROD_W-1:0]        limit;
    logic [31:0]              sat;
    logic [16:0]              coef;
    logic [FPROD_W-1:0]       fsum;
    logic [31:0]              amag;
    logic [63:0]              rnd;
    logic [48:0]              asum;

    assign o_result.valid          = r_out_valid;
    assign o_result.position_count = r_out_pos;
    assign o_result.raw_speed      = r_out_raw;
    assign o_result.filtered_speed = r_out_filt;
    assign o_result.angle_degrees  = r_out_angle;

    assign slot_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_last      = r_last;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_sprod     = r_sprod;
        n_raw       = r_raw;
        n_dlt       = r_dlt;
        n_fprod     = r_fprod;
        n_filt      = r_filt;
        n_aneg      = r_aneg;
        n_aprod     = r_aprod;
        n_angle     = r_angle;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_pos   = r_out_pos;
        n_out_raw   = r_out_raw;
        n_out_filt  = r_out_filt;
        n_out_angle = r_out_angle;
        o_pop       = 1'b0;
        load        = 1'b0;
        du          = r_count - r_last;
        limit       = r_neg ? PROD_W'(32'h8000_0000) : PROD_W'(32'h7FFF_FFFF);
        sat         = (r_sprod > limit) ? limit[31:0] : r_sprod[31:0];
        coef        = (i_cfg.filter_coef > COEF_ONE) ? COEF_ONE : i_cfg.filter_coef;
        fsum        = {{3{r_filt[31]}}, r_filt, 16'h0000} + r_fprod
                      + FPROD_W'(32768);
        amag        = r_filt[31] ? (~r_filt + 32'd1) : r_filt;
        rnd         = r_aprod + 64'h0000_0000_0080_0000;
        asum        = r_aneg ? ({r_angle[47], r_angle} - 49'(rnd[63:24]))
                             : ({r_angle[47], r_angle} + 49'(rnd[63:24]));

        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    if (i_cmd == CMD_TICK) begin
                        o_pop   = 1'b1;
                        n_neg   = du[COUNT_WIDTH-1];
                        n_mag   = du[COUNT_WIDTH-1] ? (~du + COUNT_WIDTH'(1)) : du;
                        n_last  = r_count;
                        n_state = BK_SPMUL;
                    end else if (slot_free) begin
                        o_pop = 1'b1;
                        load  = 1'b1;
                        case (i_cmd)
                            CMD_UP:   n_count = r_count + COUNT_WIDTH'(1);
                            CMD_DOWN: n_count = r_count - COUNT_WIDTH'(1);
                            default:  n_count = r_count;
                        endcase
                    end
                end
            end
            BK_SPMUL: begin
                n_sprod = PROD_W'(r_mag) * PROD_W'(i_cfg.speed_scale);
                n_state = BK_SAT;
            end
            BK_SAT: begin
                n_raw   = r_neg ? (~sat + 32'd1) : sat;
                n_dlt   = {n_raw[31], n_raw} - {r_filt[31], r_filt};
                n_state = BK_FMUL;
            end
            BK_FMUL: begin
                n_fprod = $signed({1'b0, coef}) * r_dlt;
                n_state = BK_FILT;
            end
            BK_FILT: begin
                n_filt  = fsum[47:16];
                n_state = BK_AMUL;
            end
            BK_AMUL: begin
                n_aneg  = r_filt[31];
                n_aprod = 64'(amag) * 64'(i_cfg.angle_scale);
                n_state = BK_ACC;
            end
            BK_ACC: begin
                if (slot_free) begin
                    if (asum[48] != asum[47]) begin
                        n_angle = asum[48] ? ANGLE_MIN : ANGLE_MAX;
                    end else begin
                        n_angle = asum[47:0];
                    end
                    load    = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
            n_out_pos   = n_count[31:0];
            n_out_raw   = n_raw;
            n_out_filt  = n_filt;
            n_out_angle = n_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last      <= '0;
            r_raw       <= '0;
            r_filt      <= '0;
            r_angle     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_last      <= n_last;
            r_raw       <= n_raw;
            r_filt      <= n_filt;
            r_angle     <= n_angle;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag       <= n_mag;
        r_neg       <= n_neg;
        r_sprod     <= n_sprod;
        r_dlt       <= n_dlt;
        r_fprod     <= n_fprod;
        r_aneg      <= n_aneg;
        r_aprod     <= n_aprod;
        r_out_pos   <= n_out_pos;
        r_out_raw   <= n_out_raw;
        r_out_filt  <= n_out_filt;
        r_out_angle <= n_out_angle;
    end

endmodule
